FILE: src/pal_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the positional array list.
// No dependencies; used by pal_cell and positional_array_list_core.
package pal_pkg;

  localparam int VAL_W     = 32;
  localparam int POS_W     = 8;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 2;
  // Wide enough for a count up to the largest supported capacity (1024).
  localparam int CNT_MAX_W = 11;

  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
  localparam logic [OP_W-1:0] OP_LOCATE   = 3'd3;
  localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                        en;
    logic                        shift_up;
    logic                        shift_dn;
    logic                        locate;
    logic                        fetch;
    logic [POS_W-1:0]            pos_idx;
    logic [CNT_MAX_W-1:0]        count;
    logic signed [VAL_W-1:0]     value;
  } cell_ctl_t;

endpackage

FILE: src/pal_cell.sv
`timescale 1ns / 1ps
// One list cell: holds one entry, shifts from its neighbors, flags a match.
// Depends on pal_pkg.
module pal_cell
  import pal_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic signed [VAL_W-1:0] right_data,
  output logic signed [VAL_W-1:0] data,
  output logic                    flag
);

  localparam logic [CNT_MAX_W-1:0] IDX = CNT_MAX_W'(INDEX);

  logic signed [VAL_W-1:0] data_r, data_nxt;
  logic                    flag_r, flag_nxt;
  logic [CNT_MAX_W-1:0]    pos_ext;

  assign pos_ext = CNT_MAX_W'(ctl.pos_idx);

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift_up) begin
      if (IDX == pos_ext) begin
        data_nxt = ctl.value;
      end else if (IDX > pos_ext) begin
        data_nxt = left_data;
      end
    end else if (ctl.shift_dn && (IDX >= pos_ext)) begin
      data_nxt = right_data;
    end
  end

  always_comb begin
    flag_nxt = (ctl.locate && (data_r == ctl.value) && (IDX < ctl.count)) ||
               (ctl.fetch && (IDX == pos_ext));
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.en) begin
      flag_r <= flag_nxt;
    end
  end

  assign data = data_r;
  assign flag = flag_r;

endmodule

FILE: src/positional_array_list_core.sv
`timescale 1ns / 1ps
// Top level of the positional array list: request decode, length counter,
// the chain of pal_cell entries and the result path. Depends on pal_pkg, pal_cell.
//
// An ordered list of signed 32-bit entries, addressed by 1-based position,
// held in a row of CAPACITY cells. A request transfers at a rising edge with
// start high and busy low. Each request passes through S_CMP, then S_OUT: in
// S_CMP the cells shift (insert moves later entries up, delete moves them down)
// and each cell registers its own compare result; in S_OUT the result is
// put together from those flags - a first-match search for locate, a
// one-hot select for retrieve - and shown for exactly one cycle with
// out_valid high. busy is high only in S_CMP, so a new request may transfer
// in the cycle its predecessor's result is shown. The receiver cannot stall:
// each result is taken in the cycle it appears. Entries beyond the current
// length are never read, so the cells need no clearing after reset; reset
// clears only the length and the sequencer. out_length and out_found_position
// carry the low 8 bits of their values.
module positional_array_list_core
  import pal_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_op,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [VAL_W-1:0]  out_read_value,
  output logic [POS_W-1:0]         out_found_position,
  output logic                     out_found,
  output logic [POS_W-1:0]         out_length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [OP_W-1:0]          op_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [VAL_W-1:0]  val_r;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic                     accept;

  logic [CMP_W-1:0]         cnt_ext, pos_ext;
  logic                     ins_ok, del_ok, ret_ok;
  cell_ctl_t                ctl;

  logic signed [VAL_W-1:0]  cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_flag;

  logic signed [VAL_W-1:0]  sel_data;
  logic [IDX_W-1:0]         hit_idx;
  logic                     any_hit;
  logic [CMP_W-1:0]         loc_pos;

  // A request transfers while idle or while the previous result is shown.
  assign busy   = (state_r == S_CMP);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_OUT;
      S_OUT:   state_nxt = accept ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Range checks against the length before the operation.
  assign cnt_ext = CMP_W'(count_r);
  assign pos_ext = CMP_W'(pos_r);
  assign ins_ok  = (cnt_ext < CAP_C) && (pos_r != '0) && (pos_ext <= cnt_ext + 1'b1);
  assign del_ok  = (count_r != '0) && (pos_r != '0) && (pos_ext <= cnt_ext);
  assign ret_ok  = (pos_r != '0) && (pos_ext <= cnt_ext);

  always_comb begin
    status_nxt = status_r;
    count_nxt  = count_r;
    if (state_r == S_CMP) begin
      unique case (op_r)
        OP_CLEAR: begin
          status_nxt = ST_OK;
          count_nxt  = '0;
        end
        OP_INSERT: begin
          if (cnt_ext >= CAP_C) begin
            status_nxt = ST_FULL;
          end else if (!ins_ok) begin
            status_nxt = ST_BADPOS;
          end else begin
            status_nxt = ST_OK;
            count_nxt  = count_r + 1'b1;
          end
        end
        OP_DELETE: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else if (!del_ok) begin
            status_nxt = ST_BADPOS;
          end else begin
            status_nxt = ST_OK;
            count_nxt  = count_r - 1'b1;
          end
        end
        OP_LOCATE:   status_nxt = ST_OK;
        OP_RETRIEVE: status_nxt = ret_ok ? ST_OK : ST_BADPOS;
        default:     status_nxt = ST_BADPOS;
      endcase
    end
  end

  // Broadcast control to the chain; only the compare cycle acts on it.
  always_comb begin
    ctl          = '0;
    ctl.en       = (state_r == S_CMP);
    ctl.shift_up = ctl.en && (op_r == OP_INSERT) && ins_ok;
    ctl.shift_dn = ctl.en && (op_r == OP_DELETE) && del_ok;
    ctl.locate   = ctl.en && (op_r == OP_LOCATE);
    ctl.fetch    = ctl.en && (op_r == OP_RETRIEVE) && ret_ok;
    ctl.pos_idx  = pos_r - 1'b1;
    ctl.count    = CNT_MAX_W'(count_r);
    ctl.value    = val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the request and the status; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      pos_r <= in_position;
      val_r <= in_value;
    end
    status_r <= status_nxt;
  end

  // The chain: each cell takes its lower neighbor on insert and its upper
  // neighbor on delete. The ends take the new value and their own entry.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_d, right_d;
    if (g == 0) begin : g_lo
      assign left_d = val_r;
    end else begin : g_lo
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign right_d = cell_data[g];
    end else begin : g_hi
      assign right_d = cell_data[g+1];
    end
    pal_cell #(
      .INDEX(g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .flag       (cell_flag[g])
    );
  end

  // Retrieve: at most one flag is set, so an AND-OR select suffices.
  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_data = sel_data | (cell_flag[i] ? cell_data[i] : '0);
    end
  end

  // Locate: lowest flagged cell wins.
  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_flag[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit = |cell_flag;
  assign loc_pos = any_hit ? (CMP_W'(hit_idx) + 1'b1) : (cnt_ext + 1'b1);

  assign out_valid          = (state_r == S_OUT);
  assign out_status         = status_r;
  assign out_read_value     = (op_r == OP_RETRIEVE) ? sel_data : '0;
  assign out_found          = (op_r == OP_LOCATE) && any_hit;
  assign out_found_position = (op_r == OP_LOCATE) ? loc_pos[POS_W-1:0] : '0;
  assign out_length         = POS_W'(count_r);

endmodule
